@@ sv/tmf_pkg.sv @@
// ----------------------------------------------------------------------------
// tmf_pkg
// Shared types and constants for the temporal median pixel filter.
// ----------------------------------------------------------------------------
`default_nettype none

package tmf_pkg;

	localparam int MAX_FRAMES = 16;
	localparam int MAX_PIXELS = 4096;

	localparam int SLOT_W   = $clog2(MAX_FRAMES);
	localparam int POS_W    = $clog2(MAX_PIXELS);
	localparam int NF_W     = 5;
	localparam int NP_W     = 13;
	localparam int ADDR_W   = SLOT_W + POS_W;
	localparam int DEPTH    = MAX_FRAMES * MAX_PIXELS;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PIXELS = 2'd1;

	localparam logic [NF_W-1:0] FRAMES_RESET = 5'd15;
	localparam logic [NP_W-1:0] PIXELS_RESET = 13'd4096;

	// Reciprocal of three for sums up to 765: floor(s * 683 / 2048) is exact.
	localparam logic [9:0] RECIP3 = 10'd683;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] median_value;
		logic       history_valid;
		logic       frame_end;
	} pix_out_t;

	typedef struct packed {
		logic [7:0]        gray;
		logic [SLOT_W-1:0] slot;
		logic [POS_W-1:0]  pos;
		logic [NF_W-1:0]   nf;
		logic              valid;
		logic              last;
	} cmd_t;

endpackage

`default_nettype wire

@@ sv/tmf_ram.sv @@
// ----------------------------------------------------------------------------
// tmf_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ sv/tmf_front.sv @@
// ----------------------------------------------------------------------------
// tmf_front
// Accepts pixels, converts them to gray and tags each with its history slot,
// position and validity. Holds the configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tmf_front (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire tmf_pkg::pix_in_t                   in_data,
	input  wire logic                               cfg_we,
	input  wire logic [tmf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [tmf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	output logic                                    push,
	output tmf_pkg::cmd_t                           cmd,
	input  wire logic                               q_full
);

	logic [tmf_pkg::NF_W-1:0]   frames_q;
	logic [tmf_pkg::NP_W-1:0]   pixels_q;
	logic [tmf_pkg::SLOT_W-1:0] slot_q;
	logic [tmf_pkg::POS_W-1:0]  pos_q;
	logic                       full_q;

	logic [tmf_pkg::NF_W-1:0]   nf;
	logic [tmf_pkg::NP_W-1:0]   np;
	logic [9:0]                 sum;
	logic [19:0]                prod;
	logic                       last;
	logic                       wrap;

	always_comb begin
		if (frames_q == '0) begin
			nf = tmf_pkg::NF_W'(1);
		end else if (frames_q > tmf_pkg::NF_W'(tmf_pkg::MAX_FRAMES)) begin
			nf = tmf_pkg::NF_W'(tmf_pkg::MAX_FRAMES);
		end else begin
			nf = frames_q;
		end
		if (pixels_q == '0) begin
			np = tmf_pkg::NP_W'(1);
		end else if (pixels_q > tmf_pkg::NP_W'(tmf_pkg::MAX_PIXELS)) begin
			np = tmf_pkg::NP_W'(tmf_pkg::MAX_PIXELS);
		end else begin
			np = pixels_q;
		end
	end

	assign sum  = 10'(in_data.red) + 10'(in_data.green) + 10'(in_data.blue);
	assign prod = 20'(sum) * 20'(tmf_pkg::RECIP3);
	assign last = (14'(pos_q) + 14'd1) >= 14'(np);
	assign wrap = (6'(slot_q) + 6'd1) >= 6'(nf);

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	always_comb begin
		cmd.gray  = prod[18:11];
		cmd.slot  = slot_q;
		cmd.pos   = pos_q;
		cmd.nf    = nf;
		cmd.valid = full_q || wrap;
		cmd.last  = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= tmf_pkg::FRAMES_RESET;
			pixels_q <= tmf_pkg::PIXELS_RESET;
			slot_q   <= '0;
			pos_q    <= '0;
			full_q   <= 1'b0;
		end else if (cfg_we && (cfg_index == tmf_pkg::CFG_FRAMES ||
				cfg_index == tmf_pkg::CFG_PIXELS)) begin
			if (cfg_index == tmf_pkg::CFG_FRAMES) begin
				frames_q <= cfg_wdata[tmf_pkg::NF_W-1:0];
			end else begin
				pixels_q <= cfg_wdata;
			end
			// A write to the frames or pixels register restarts filling the history.
			slot_q <= '0;
			pos_q  <= '0;
			full_q <= 1'b0;
		end else if (push) begin
			if (last) begin
				pos_q <= '0;
				if (wrap) begin
					slot_q <= '0;
					full_q <= 1'b1;
				end else begin
					slot_q <= slot_q + 1'b1;
				end
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/tmf_fifo.sv @@
// ----------------------------------------------------------------------------
// tmf_fifo
// Two-entry queue of pixel commands between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module tmf_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire tmf_pkg::cmd_t push_data,
	output logic               full,
	input  wire logic          pop,
	output tmf_pkg::cmd_t      pop_data,
	output logic               empty
);

	tmf_pkg::cmd_t ent_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;

	assign full     = count_q == 2'd2;
	assign empty    = count_q == 2'd0;
	assign pop_data = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/tmf_back.sv @@
// ----------------------------------------------------------------------------
// tmf_back
// Writes each gray value into the history, reads back the pixel's frames,
// sorts them by insertion and produces the median result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module tmf_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_empty,
	output logic               pop,
	input  wire tmf_pkg::cmd_t q_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output tmf_pkg::pix_out_t  out_data
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_READ  = 5'b00010,
		ST_LAST  = 5'b00100,
		ST_SHIFT = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	state_t                     state_q;
	tmf_pkg::cmd_t              cmd_q;
	logic [tmf_pkg::SLOT_W-1:0] rd_idx_q;
	logic                       rd_vld_q;
	logic [tmf_pkg::SLOT_W-1:0] shift_q;
	logic [7:0]                 v_q [tmf_pkg::MAX_FRAMES];
	logic [7:0]                 v_ins [tmf_pkg::MAX_FRAMES];
	tmf_pkg::pix_out_t          res_q;

	logic                       ram_we;
	logic [tmf_pkg::ADDR_W-1:0] ram_waddr;
	logic                       ram_re;
	logic [tmf_pkg::ADDR_W-1:0] ram_raddr;
	logic [7:0]                 ram_rdata;
	logic [8:0]                 pair_sum;

	assign pop       = (state_q == ST_IDLE) && !q_empty;
	assign ram_we    = pop;
	assign ram_waddr = {q_data.slot, q_data.pos};
	assign ram_re    = state_q == ST_READ;
	assign ram_raddr = {rd_idx_q, cmd_q.pos};

	tmf_ram #(
		.WIDTH (8),
		.DEPTH (tmf_pkg::DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (q_data.gray),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Parallel insertion of the returning value into the ascending list.
	// Unused entries hold the top value so they stay at the end.
	always_comb begin
		for (int j = 0; j < tmf_pkg::MAX_FRAMES; j++) begin
			if (v_q[j] <= ram_rdata) begin
				v_ins[j] = v_q[j];
			end else if (j == 0) begin
				v_ins[j] = ram_rdata;
			end else if (v_q[(j == 0) ? 0 : j-1] <= ram_rdata) begin
				v_ins[j] = ram_rdata;
			end else begin
				v_ins[j] = v_q[(j == 0) ? 0 : j-1];
			end
		end
	end

	assign pair_sum = 9'(v_q[0]) + 9'(v_q[1]);

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= q_data;
			for (int j = 0; j < tmf_pkg::MAX_FRAMES; j++) begin
				v_q[j] <= 8'hFF;
			end
		end else if (rd_vld_q) begin
			v_q <= v_ins;
		end else if (state_q == ST_SHIFT && shift_q != '0) begin
			for (int j = 0; j < tmf_pkg::MAX_FRAMES - 1; j++) begin
				v_q[j] <= v_q[j+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rd_idx_q <= '0;
			rd_vld_q <= 1'b0;
			shift_q  <= '0;
			res_q    <= '0;
		end else begin
			rd_vld_q <= state_q == ST_READ;
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						rd_idx_q <= '0;
						res_q.history_valid <= q_data.valid;
						res_q.frame_end     <= q_data.last;
						res_q.median_value  <= '0;
						state_q <= q_data.valid ? ST_READ : ST_OUT;
					end
				end
				ST_READ: begin
					rd_idx_q <= rd_idx_q + 1'b1;
					if (tmf_pkg::NF_W'(rd_idx_q) == cmd_q.nf - 1'b1) begin
						state_q <= ST_LAST;
					end
				end
				ST_LAST: begin
					// Middle index is (count - 1) / 2 for odd and even counts.
					shift_q <= tmf_pkg::SLOT_W'((cmd_q.nf - 1'b1) >> 1);
					state_q <= ST_SHIFT;
				end
				ST_SHIFT: begin
					if (shift_q == '0) begin
						if (cmd_q.nf[0]) begin
							res_q.median_value <= v_q[0];
						end else begin
							res_q.median_value <= pair_sum[8:1];
						end
						state_q <= ST_OUT;
					end else begin
						shift_q <= shift_q - 1'b1;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = state_q == ST_OUT;
	assign out_data  = res_q;

endmodule

`default_nettype wire

@@ sv/temporal_median_pixel_filter.sv @@
// ----------------------------------------------------------------------------
// temporal_median_pixel_filter
// Per-pixel temporal median of gray values over a ring of stored frames.
//
//   channel | signals                          | direction
//   in      | in_valid, in_ready, in_data      | pixel beat in
//   out     | out_valid, out_ready, out_data   | median beat out
//   cfg     | cfg_we, cfg_index, cfg_wdata     | register write in
//
// A valid pixel's time in the back end (nf frames in use) is set by the single
// history read port and the shift to the middle.
// A pixel whose history is not yet full skips the read and shift and goes straight to output.
// A two-entry queue lets the front accept pixels while the back is busy.
// Reset clears the counters; the history memory has no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module temporal_median_pixel_filter (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire tmf_pkg::pix_in_t               in_data,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output tmf_pkg::pix_out_t                   out_data,
	input  wire logic                           cfg_we,
	input  wire logic [tmf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tmf_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	logic          push;
	logic          pop;
	logic          q_full;
	logic          q_empty;
	tmf_pkg::cmd_t push_cmd;
	tmf_pkg::cmd_t pop_cmd;

	tmf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.cmd       (push_cmd),
		.q_full    (q_full)
	);

	tmf_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_cmd),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_cmd),
		.empty     (q_empty)
	);

	tmf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.pop       (pop),
		.q_data    (pop_cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire
